@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/alif_pkg.sv @@
package alif_pkg;

    localparam int DATA_W     = 24;
    localparam int BASE_W     = 23;
    localparam int GAIN_W     = 24;
    localparam int STEP_W     = 23;
    localparam int IDX_W      = 6;
    localparam int NEURONS    = 2 ** IDX_W;
    localparam int FRAC_BITS  = 16;
    localparam int COEF_BITS  = 16;
    localparam int REFR_W     = 2;
    localparam int REFRACTORY_TICKS = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // shared multiplier: 25 x 25 signed
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;
    localparam int Q_W    = 40;
    localparam int SUM_W  = Q_W + 1;

    localparam int LEAK_Q      = 55706;
    localparam int ABS_GAIN_Q  = 3277;
    localparam int THR_DECAY_Q = 62259;
    localparam int MEM_MAX     = 2 ** (DATA_W - 1) - 1;
    localparam int MEM_MIN     = -(2 ** (DATA_W - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE = 2'd0,
        CFG_GAIN = 2'd1,
        CFG_STEP = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MUL_QGAIN,
        MUL_QSTEP,
        MUL_LEAK,
        MUL_ABS,
        MUL_DECAY
    } mul_op_t;

    typedef struct packed {
        logic    load_item;
        logic    latch_mem;
        logic    mul_en;
        mul_op_t mul_op;
        logic    latch_q;
        logic    latch_sum;
        logic    latch_thr;
        logic    refr_result;
        logic    fire_commit;
    } cmd_t;

    typedef struct packed {
        logic refr_busy;
    } status_t;

    // shift right rounding half away from zero
    function automatic logic signed [PROD_W-1:0] round_shift(
        input logic signed [PROD_W-1:0] v,
        input int                       sh
    );
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] half;
        mag  = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
        half = PROD_W'(1) << (sh - 1);
        mag  = (mag + half) >> sh;
        return v[PROD_W-1] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

@@ hw/rtl/alif_in_if.sv @@
interface alif_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [alif_pkg::DATA_W-1:0]  input_value;
    logic        [alif_pkg::IDX_W-1:0]   neuron_index;

    modport source (output valid, output input_value, output neuron_index, input ready);
    modport sink   (input valid, input input_value, input neuron_index, output ready);
endinterface

@@ hw/rtl/alif_out_if.sv @@
interface alif_out_if;
    logic valid;
    logic ready;
    logic spike;
    logic was_refractory;

    modport source (output valid, output spike, output was_refractory, input ready);
    modport sink   (input valid, input spike, input was_refractory, output ready);
endinterface

@@ hw/rtl/alif_ram.sv @@
module alif_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/alif_dp.sv @@
`include "assert_macros.svh"

module alif_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  alif_pkg::cmd_t                         cmd,
    output alif_pkg::status_t                      status,
    input  logic signed [alif_pkg::DATA_W-1:0]     input_value,
    input  logic        [alif_pkg::IDX_W-1:0]      neuron_index,
    input  logic                                   cfg_we,
    input  logic        [alif_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [alif_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                                   spike,
    output logic                                   was_refractory
);

    logic        [alif_pkg::BASE_W-1:0] base_reg;
    logic        [alif_pkg::GAIN_W-1:0] gain_reg;
    logic        [alif_pkg::STEP_W-1:0] step_reg;
    logic signed [alif_pkg::DATA_W-1:0] x_reg;
    logic        [alif_pkg::IDX_W-1:0]  idx_reg;
    logic signed [alif_pkg::DATA_W-1:0] mem_reg;
    logic signed [alif_pkg::Q_W-1:0]    q_reg;
    logic        [alif_pkg::DATA_W-1:0] thr_reg;
    logic signed [alif_pkg::PROD_W-1:0] prod_reg;
    logic signed [alif_pkg::PROD_W-1:0] prod_next;
    logic        [alif_pkg::REFR_W-1:0] refr_reg;
    logic        [alif_pkg::NEURONS-1:0] valid_reg;
    logic                               spike_reg;
    logic                               was_refr_reg;

    logic signed [alif_pkg::MUL_W-1:0]  mul_a;
    logic signed [alif_pkg::MUL_W-1:0]  mul_b;
    logic signed [alif_pkg::PROD_W-1:0] rnd32;
    logic signed [alif_pkg::PROD_W-1:0] rnd16;
    logic signed [alif_pkg::MUL_W-1:0]  n_val;
    logic signed [alif_pkg::SUM_W-1:0]  sum;
    logic signed [alif_pkg::DATA_W-1:0] sat_mem;
    logic        [alif_pkg::DATA_W-1:0] mag;
    logic        [alif_pkg::DATA_W-1:0] thr_fin;
    logic        [alif_pkg::DATA_W-1:0] half_base;
    logic signed [alif_pkg::DATA_W-1:0] reset_mem;
    logic signed [alif_pkg::DATA_W-1:0] wr_mem;
    logic                               fire;
    logic        [alif_pkg::DATA_W-1:0] rdata;

    assign rnd32 = alif_pkg::round_shift(prod_reg, 2 * alif_pkg::FRAC_BITS);
    assign rnd16 = alif_pkg::round_shift(prod_reg, alif_pkg::COEF_BITS);
    assign n_val = rnd32[alif_pkg::MUL_W-1:0];

    always_comb
    begin
        unique case (cmd.mul_op)
            alif_pkg::MUL_QGAIN:
            begin
                mul_a = alif_pkg::MUL_W'(x_reg);
                mul_b = $signed({1'b0, gain_reg});
            end
            alif_pkg::MUL_QSTEP:
            begin
                mul_a = n_val;
                mul_b = $signed({2'b0, step_reg});
            end
            alif_pkg::MUL_LEAK:
            begin
                mul_a = alif_pkg::MUL_W'(mem_reg);
                mul_b = alif_pkg::MUL_W'(alif_pkg::LEAK_Q);
            end
            alif_pkg::MUL_ABS:
            begin
                mul_a = $signed({1'b0, mag});
                mul_b = alif_pkg::MUL_W'(alif_pkg::ABS_GAIN_Q);
            end
            alif_pkg::MUL_DECAY:
            begin
                mul_a = $signed({1'b0, thr_reg});
                mul_b = alif_pkg::MUL_W'(alif_pkg::THR_DECAY_Q);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // leaked membrane plus quantised input, clamped to the membrane range
    always_comb
    begin
        sum = alif_pkg::SUM_W'(rnd16[alif_pkg::SUM_W-1:0]) + alif_pkg::SUM_W'(q_reg);
        if (sum > alif_pkg::SUM_W'(alif_pkg::MEM_MAX))
        begin
            sat_mem = alif_pkg::DATA_W'(alif_pkg::MEM_MAX);
        end
        else if (sum < alif_pkg::SUM_W'(alif_pkg::MEM_MIN))
        begin
            sat_mem = alif_pkg::DATA_W'(alif_pkg::MEM_MIN);
        end
        else
        begin
            sat_mem = sum[alif_pkg::DATA_W-1:0];
        end
    end

    assign mag       = mem_reg[alif_pkg::DATA_W-1] ? alif_pkg::DATA_W'(-mem_reg)
                                                   : alif_pkg::DATA_W'(mem_reg);
    assign thr_fin   = rnd16[alif_pkg::DATA_W-1:0];
    assign fire      = $signed({mem_reg[alif_pkg::DATA_W-1], mem_reg}) > $signed({1'b0, thr_fin});
    assign half_base = (alif_pkg::DATA_W'(base_reg) + alif_pkg::DATA_W'(1)) >> 1;
    assign reset_mem = -$signed(half_base);
    assign wr_mem    = fire ? reset_mem : mem_reg;

    alif_ram #(
        .WIDTH (alif_pkg::DATA_W),
        .DEPTH (alif_pkg::NEURONS)
    ) u_membrane (
        .clk   (clk),
        .we    (cmd.fire_commit),
        .waddr (idx_reg),
        .wdata (wr_mem),
        .re    (cmd.load_item),
        .raddr (neuron_index),
        .rdata (rdata)
    );

    // config registers, valid bits and refractory counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= alif_pkg::BASE_W'(9830);
            gain_reg     <= alif_pkg::GAIN_W'(8355840);
            step_reg     <= alif_pkg::STEP_W'(514);
            valid_reg    <= '0;
            refr_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    alif_pkg::CFG_BASE: base_reg <= cfg_data[alif_pkg::BASE_W-1:0];
                    alif_pkg::CFG_GAIN: gain_reg <= cfg_data[alif_pkg::GAIN_W-1:0];
                    alif_pkg::CFG_STEP: step_reg <= cfg_data[alif_pkg::STEP_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.fire_commit)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
            if (cmd.refr_result)
            begin
                refr_reg <= refr_reg - alif_pkg::REFR_W'(1);
            end
            else if (cmd.fire_commit && fire)
            begin
                refr_reg <= alif_pkg::REFR_W'(alif_pkg::REFRACTORY_TICKS);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            x_reg   <= input_value;
            idx_reg <= neuron_index;
        end
        if (cmd.latch_mem)
        begin
            mem_reg <= valid_reg[idx_reg] ? $signed(rdata) : '0;
        end
        else if (cmd.latch_sum)
        begin
            mem_reg <= sat_mem;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.latch_q)
        begin
            q_reg <= prod_reg[alif_pkg::Q_W-1:0];
        end
        if (cmd.latch_thr)
        begin
            thr_reg <= alif_pkg::DATA_W'(base_reg) + rnd16[alif_pkg::DATA_W-1:0];
        end
        if (cmd.refr_result)
        begin
            spike_reg    <= 1'b0;
            was_refr_reg <= 1'b1;
        end
        else if (cmd.fire_commit)
        begin
            spike_reg    <= fire;
            was_refr_reg <= 1'b0;
        end
    end

    assign status.refr_busy = (refr_reg != '0);
    assign spike            = spike_reg;
    assign was_refractory   = was_refr_reg;

    `ASSERT_IMPLIES(a_refr_range, 1'b1, refr_reg <= alif_pkg::REFR_W'(alif_pkg::REFRACTORY_TICKS), "refractory count out of range")
    `ASSERT_IMPLIES(a_refr_skip, cmd.refr_result, refr_reg != '0, "refractory skip with idle counter")
    `ASSERT_NEXT(a_fire_load, cmd.fire_commit && fire, refr_reg == alif_pkg::REFR_W'(alif_pkg::REFRACTORY_TICKS), "spike did not load counter")

endmodule

@@ hw/rtl/alif_ctrl.sv @@
`include "assert_macros.svh"

module alif_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  alif_pkg::status_t status,
    output alif_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_QGAIN,
        S_QSTEP,
        S_LEAK,
        S_SUM,
        S_ABS,
        S_THRSUM,
        S_DECAY,
        S_FIRE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd        = '0;
        cmd.mul_op = alif_pkg::MUL_QGAIN;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_QGAIN;
                end
            end
            S_QGAIN:
            begin
                cmd.latch_mem = 1'b1;
                if (status.refr_busy)
                begin
                    if (out_free)
                    begin
                        cmd.refr_result = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.mul_en = 1'b1;
                    state_next = S_QSTEP;
                end
            end
            S_QSTEP:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = alif_pkg::MUL_QSTEP;
                state_next = S_LEAK;
            end
            S_LEAK:
            begin
                cmd.latch_q = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_op  = alif_pkg::MUL_LEAK;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                cmd.latch_sum = 1'b1;
                state_next    = S_ABS;
            end
            S_ABS:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = alif_pkg::MUL_ABS;
                state_next = S_THRSUM;
            end
            S_THRSUM:
            begin
                cmd.latch_thr = 1'b1;
                state_next    = S_DECAY;
            end
            S_DECAY:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = alif_pkg::MUL_DECAY;
                state_next = S_FIRE;
            end
            S_FIRE:
            begin
                if (out_free)
                begin
                    cmd.fire_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.refr_result || cmd.fire_commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    `ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_reg == S_QGAIN, "accepted item did not start")
    `ASSERT_IMPLIES(a_result_slot, cmd.refr_result || cmd.fire_commit, out_free, "result overwrote a waiting item")
    `ASSERT_NEXT(a_fire_waits, state_reg == S_FIRE && !out_free, state_reg == S_FIRE, "final step left while output full")

endmodule

@@ hw/rtl/adaptive_lif_neuron.sv @@
// channel        dir   payload                              handshake
// neuron_item    in    input_value[23:0] s, neuron_index[5:0] valid/ready
// neuron_result  out   spike, was_refractory                valid/ready
// cfg            in    cfg_index[1:0], cfg_data[23:0]       cfg_we
//
// after an item is accepted it runs through eight steps on the single 25x25 multiplier
// (five products, three add/round steps); its result is registered in the last step and the
// next item is taken only once the block is back in idle, so one item is in flight at a time
// an item that meets a busy refractory counter skips the steps; its result is registered in its first step
// the membrane store is valid-bit tracked, so no clearing pass after reset
// a result waits in the output register; a full register holds the item in its last step
module adaptive_lif_neuron (
    input  logic                                   clk,
    input  logic                                   rst_n,
    alif_in_if.sink                                neuron_item,
    alif_out_if.source                             neuron_result,
    input  logic                                   cfg_we,
    input  logic        [alif_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [alif_pkg::CFG_DATA_W-1:0] cfg_data
);

    alif_pkg::cmd_t    cmd;
    alif_pkg::status_t status;

    alif_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (neuron_item.valid),
        .in_ready  (neuron_item.ready),
        .out_valid (neuron_result.valid),
        .out_ready (neuron_result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    alif_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .input_value    (neuron_item.input_value),
        .neuron_index   (neuron_item.neuron_index),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .spike          (neuron_result.spike),
        .was_refractory (neuron_result.was_refractory)
    );

endmodule

@@ bench/lif_spike_checker.sv @@
module lif_spike_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    alif_in_if                                     items,
    alif_out_if                                    results,
    input  logic                                   cfg_we,
    input  logic        [alif_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [alif_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                     mismatch_count,
    output int                                     awaited_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic spike;
        logic was_refractory;
    } neuron_outcome_t;

    // shadow copy of the block state and registers
    logic signed [alif_pkg::DATA_W-1:0] mem_store [alif_pkg::NEURONS];
    logic        [alif_pkg::REFR_W-1:0] refr_left;
    logic        [alif_pkg::BASE_W-1:0] base_shadow;
    logic        [alif_pkg::GAIN_W-1:0] gain;
    logic        [alif_pkg::STEP_W-1:0] step;

    neuron_outcome_t awaited_outcomes [$];
    neuron_outcome_t oldest;

    function automatic longint round_away(input longint v, input int sh);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic neuron_outcome_t integrate_and_fire(
        input logic signed [alif_pkg::DATA_W-1:0] v,
        input logic        [alif_pkg::IDX_W-1:0]  n
    );
        neuron_outcome_t res;
        longint m;
        longint q;
        longint thr;
        res = '0;
        if (refr_left != 0)
        begin
            refr_left = refr_left - 1'b1;
            res.was_refractory = 1'b1;
            return res;
        end
        q = round_away(longint'(v) * longint'(gain), 2 * alif_pkg::FRAC_BITS)
            * longint'(step);
        m = round_away(longint'(mem_store[n]) * alif_pkg::LEAK_Q, alif_pkg::COEF_BITS) + q;
        if (m > alif_pkg::MEM_MAX)
            m = alif_pkg::MEM_MAX;
        else if (m < alif_pkg::MEM_MIN)
            m = alif_pkg::MEM_MIN;
        // adaptive threshold follows the new membrane magnitude
        thr = longint'(base_shadow)
              + round_away(((m < 0) ? -m : m) * alif_pkg::ABS_GAIN_Q, alif_pkg::COEF_BITS);
        thr = round_away(thr * alif_pkg::THR_DECAY_Q, alif_pkg::COEF_BITS);
        if (m > thr)
        begin
            res.spike = 1'b1;
            m = -((longint'(base_shadow) + 1) >>> 1);
            refr_left = alif_pkg::REFR_W'(alif_pkg::REFRACTORY_TICKS);
        end
        mem_store[n] = alif_pkg::DATA_W'(m);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < alif_pkg::NEURONS; i++)
                mem_store[i] = '0;
            refr_left = '0;
            base_shadow = alif_pkg::BASE_W'(9830);
            gain = alif_pkg::GAIN_W'(8355840);
            step = alif_pkg::STEP_W'(514);
            awaited_outcomes.delete();
            mismatch_count = 0;
            awaited_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    alif_pkg::CFG_BASE: base_shadow = cfg_data[alif_pkg::BASE_W-1:0];
                    alif_pkg::CFG_GAIN: gain = cfg_data[alif_pkg::GAIN_W-1:0];
                    alif_pkg::CFG_STEP: step = cfg_data[alif_pkg::STEP_W-1:0];
                    default: ;
                endcase
            end
            if (items.valid && items.ready)
                awaited_outcomes.push_back(integrate_and_fire(items.input_value,
                                                              items.neuron_index));
            if (results.valid && results.ready)
            begin
                if (awaited_outcomes.size() == 0)
                    report_mismatch("result with no item outstanding");
                else
                begin
                    oldest = awaited_outcomes.pop_front();
                    if (results.spike !== oldest.spike)
                        report_mismatch($sformatf("spike expected %0b got %0b",
                                                  oldest.spike, results.spike));
                    if (results.was_refractory !== oldest.was_refractory)
                        report_mismatch($sformatf("was_refractory expected %0b got %0b",
                                                  oldest.was_refractory,
                                                  results.was_refractory));
                end
            end
            awaited_count <= awaited_outcomes.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [alif_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 89;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [alif_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [alif_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            calm;
    int                              mismatch_count;
    int                              awaited_count;

    alif_in_if  items ();
    alif_out_if results ();

    adaptive_lif_neuron uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .neuron_item   (items),
        .neuron_result (results),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    lif_spike_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .items          (items),
        .results        (results),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        results.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            results.ready <= calm || ($urandom_range(99) >= 31);
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

    task automatic send_item(input logic signed [alif_pkg::DATA_W-1:0] v,
                             input logic [alif_pkg::IDX_W-1:0] n);
        while (!calm && $urandom_range(99) < 31)
        begin
            items.valid <= 1'b0;
            @(posedge clk);
        end
        items.valid <= 1'b1;
        items.input_value <= v;
        items.neuron_index <= n;
        do
            @(posedge clk);
        while (!items.ready);
    endtask

    // lower valid and wait for every outstanding result to be taken
    task automatic wait_idle();
        items.valid <= 1'b0;
        @(posedge clk);
        while (awaited_count != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [alif_pkg::CFG_IDX_W-1:0] idx,
                             input logic [alif_pkg::CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [alif_pkg::CFG_DATA_W-1:0] base,
                                 input logic [alif_pkg::CFG_DATA_W-1:0] g,
                                 input logic [alif_pkg::CFG_DATA_W-1:0] s);
        wait_idle();
        write_reg(alif_pkg::CFG_BASE, base);
        write_reg(alif_pkg::CFG_GAIN, g);
        write_reg(alif_pkg::CFG_STEP, s);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(99);
        // often small currents on a few neurons so membranes build up and leak
        if (pick < 45)
            send_item(alif_pkg::DATA_W'(int'($urandom_range(0, 12000)) - 2000),
                      alif_pkg::IDX_W'($urandom_range(0, 3)));
        else if (pick < 75)
            send_item(alif_pkg::DATA_W'(int'($urandom_range(0, 2097151)) - 1048576),
                      alif_pkg::IDX_W'($urandom));
        else
            send_item(alif_pkg::DATA_W'($urandom), alif_pkg::IDX_W'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        calm = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        items.valid = 1'b0;
        items.input_value = '0;
        items.neuron_index = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: zero input, extremes, refractory run, saturation, build-up
        send_item(alif_pkg::DATA_W'(0), alif_pkg::IDX_W'(0));
        send_item(alif_pkg::DATA_W'(1), alif_pkg::IDX_W'(1));
        send_item(alif_pkg::DATA_W'(-1), alif_pkg::IDX_W'(2));
        send_item(alif_pkg::DATA_W'(alif_pkg::MEM_MAX), alif_pkg::IDX_W'(63));
        send_item(alif_pkg::DATA_W'(alif_pkg::MEM_MIN), alif_pkg::IDX_W'(5));
        send_item(alif_pkg::DATA_W'(alif_pkg::MEM_MAX), alif_pkg::IDX_W'(6));
        send_item(alif_pkg::DATA_W'(alif_pkg::MEM_MIN), alif_pkg::IDX_W'(63));
        send_item(alif_pkg::DATA_W'(alif_pkg::MEM_MIN), alif_pkg::IDX_W'(63));
        send_item(alif_pkg::DATA_W'(4000), alif_pkg::IDX_W'(7));
        send_item(alif_pkg::DATA_W'(4000), alif_pkg::IDX_W'(7));
        send_item(alif_pkg::DATA_W'(4000), alif_pkg::IDX_W'(7));
        send_item(alif_pkg::DATA_W'(4000), alif_pkg::IDX_W'(7));

        // bits above a register's width are dropped, the unused index is ignored
        wait_idle();
        write_reg(alif_pkg::CFG_BASE, 24'h800000 | 24'd4000);
        write_reg(alif_pkg::CFG_GAIN, 24'hFFFFFF);
        write_reg(alif_pkg::CFG_STEP, 24'h800000 | 24'd1028);
        write_reg(CFG_UNUSED, alif_pkg::CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        send_item(alif_pkg::DATA_W'(300), alif_pkg::IDX_W'(8));
        send_item(alif_pkg::DATA_W'(-300), alif_pkg::IDX_W'(9));
        send_item(alif_pkg::DATA_W'(1500), alif_pkg::IDX_W'(8));

        // zero gain, then zero step: quantized input vanishes
        load_settings(24'd9830, 24'd0, 24'd514);
        send_item(alif_pkg::DATA_W'(alif_pkg::MEM_MAX), alif_pkg::IDX_W'(10));
        send_item(alif_pkg::DATA_W'(alif_pkg::MEM_MIN), alif_pkg::IDX_W'(11));
        load_settings(24'd9830, 24'd8355840, 24'd0);
        send_item(alif_pkg::DATA_W'(alif_pkg::MEM_MAX), alif_pkg::IDX_W'(12));
        send_item(alif_pkg::DATA_W'(-5000), alif_pkg::IDX_W'(7));

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: load_settings(24'd9830, 24'd1966080, 24'd2185);
                1: load_settings(24'h7FFFFF, 24'hFFFFFF, 24'h7FFFFF);
                2: load_settings(24'd0, 24'd0, 24'd0);
                3: load_settings(24'd9830, 24'd8355840, 24'd514);
                4: load_settings(alif_pkg::CFG_DATA_W'($urandom),
                                 alif_pkg::CFG_DATA_W'($urandom),
                                 alif_pkg::CFG_DATA_W'($urandom));
                default: load_settings(24'd6554, 24'd4177920, 24'd1028);
            endcase
            calm <= (ph == 3);
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_random_item();
        end
        calm <= 1'b0;

        wait_idle();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
